/* hdl/ffha_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package ffha_pkg;

   // request kinds carried on req_tuser
   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   // result status carried on rsp_tuser
   localparam logic [1:0] STATUS_ALLOCATED = 2'd0;
   localparam logic [1:0] STATUS_NO_FIT    = 2'd1;
   localparam logic [1:0] STATUS_FREED     = 2'd2;
   localparam logic [1:0] STATUS_IGNORED   = 2'd3;

   // granule is 16 bytes
   localparam int GRAN_SHIFT = 4;
   // granules needed for a 16-bit request plus header: at most 4097
   localparam int NEED_W = 13;

   typedef enum logic [3:0] {
      ST_INIT,
      ST_IDLE,
      ST_A_CHK,
      ST_A_SPLIT,
      ST_A_LINK,
      ST_A_TAKE,
      ST_F_CHK,
      ST_F_AFTER,
      ST_F_WT,
      ST_F_WL,
      ST_RESP
   } state_type;

endpackage

`default_nettype wire

/* hdl/ffha_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module ffha_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* hdl/first_fit_heap_allocator.sv */
`timescale 1ns / 1ps
`default_nettype none

// First-fit heap allocator over a heap of HEAP_BYTES bytes cut into 16-byte granules; every
// block carries a one-granule header kept in a single-port-write, registered-read header RAM
// of HEAP_BYTES/16 entries. An allocate request (req_tuser = 0) rounds request_size up to
// 16, adds the header granule, walks the address-ordered free list and takes the first block
// that fits, splitting off any remainder; it answers status 0 with the data offset (modulo
// 2^16) or status 1 when nothing fits. A free request (req_tuser = 1) walks the heap block by
// block from offset 0 to find the block whose data starts at free_address, links it into the
// free list and merges it with free neighbors after and before it; it answers status 2, or
// status 3 for null, misaligned, unknown or already-free offsets. One request is in work at a
// time and the header RAM port paces it: one header is read per cycle. An allocate reads
// each free block it visits and then writes up to three headers; a free reads every heap
// block below the freed one, then any block right after it, and writes its own header and
// that of any free block before it. After reset the block writes the first header before
// it takes requests. A finished result sits in an output register, so the next request is
// accepted while it waits.
module first_fit_heap_allocator #(
   parameter int HEAP_BYTES = 65536
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // [15:0] request_size, [31:16] free_address
   input  wire logic        req_tuser,   // [0] command
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [15:0] rsp_tdata,   // [15:0] data_address
   output logic      [1:0]  rsp_tuser    // [1:0] status
);

   // granule count; the value NGRAN itself serves as the null link
   localparam int NGRAN = HEAP_BYTES / 16;
   localparam int GW    = $clog2(NGRAN + 1);
   localparam int AW    = $clog2(NGRAN);
   localparam int HW    = 2 * GW + 1;
   localparam logic [GW-1:0] NIL = GW'(NGRAN);

   // header layout: {size in granules, next free block, in use}
   ffha_pkg::state_type state_ff, state_in;

   logic [GW-1:0]               first_free_ff, first_free_in;
   logic [GW-1:0]               cur_ff, cur_in;          // list cursor / heap walk
   logic [GW-1:0]               prev_ff, prev_in;        // previous free block, NIL if none
   logic [GW-1:0]               prev_size_ff, prev_size_in;
   logic [GW-1:0]               prev_next_ff, prev_next_in;
   logic [GW-1:0]               target_ff, target_in;
   logic [GW-1:0]               hsize_ff, hsize_in;      // working header of chosen block
   logic [GW-1:0]               hnext_ff, hnext_in;
   logic [GW-1:0]               link_ff, link_in;
   logic [ffha_pkg::NEED_W-1:0] need_ff, need_in;
   logic [1:0]                  res_status_ff, res_status_in;
   logic [15:0]                 res_addr_ff, res_addr_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [1:0]                  rsp_status_ff, rsp_status_in;
   logic [15:0]                 rsp_addr_ff, rsp_addr_in;

   // header RAM port
   logic          rd_en;
   logic [GW-1:0] rd_idx;
   logic [HW-1:0] rd_data;
   logic          wr_en;
   logic [GW-1:0] wr_idx;
   logic [HW-1:0] wr_data;

   logic [GW-1:0] rsize;
   logic [GW-1:0] rnext;
   logic          rused;

   logic          req_accept;
   logic [15:0]   req_size;
   logic [15:0]   req_addr;
   logic [16:0]   round_sum;
   logic [31:0]   target_wide;
   logic [31:0]   cur_plus;
   logic [GW:0]   walk_sum;
   logic [GW:0]   after_sum;
   logic [GW:0]   prev_end;
   logic [31:0]   rest_wide;

   assign rsize = rd_data[HW-1 -: GW];
   assign rnext = rd_data[GW:1];
   assign rused = rd_data[0];

   assign req_size   = req_tdata[15:0];
   assign req_addr   = req_tdata[31:16];
   assign req_tready = (state_ff == ffha_pkg::ST_IDLE);
   assign req_accept = req_tvalid && req_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_addr_ff;
   assign rsp_tuser  = rsp_status_ff;

   ffha_ram #(
      .WIDTH(HW),
      .DEPTH(NGRAN)
   ) u_hdr_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_idx[AW-1:0]),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_idx[AW-1:0]),
      .rd_data(rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ffha_pkg::ST_INIT;
         first_free_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         first_free_ff <= first_free_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      cur_ff        <= cur_in;
      prev_ff       <= prev_in;
      prev_size_ff  <= prev_size_in;
      prev_next_ff  <= prev_next_in;
      target_ff     <= target_in;
      hsize_ff      <= hsize_in;
      hnext_ff      <= hnext_in;
      link_ff       <= link_in;
      need_ff       <= need_in;
      res_status_ff <= res_status_in;
      res_addr_ff   <= res_addr_in;
      rsp_status_ff <= rsp_status_in;
      rsp_addr_ff   <= rsp_addr_in;
   end

   always_comb begin
      state_in      = state_ff;
      first_free_in = first_free_ff;
      cur_in        = cur_ff;
      prev_in       = prev_ff;
      prev_size_in  = prev_size_ff;
      prev_next_in  = prev_next_ff;
      target_in     = target_ff;
      hsize_in      = hsize_ff;
      hnext_in      = hnext_ff;
      link_in       = link_ff;
      need_in       = need_ff;
      res_status_in = res_status_ff;
      res_addr_in   = res_addr_ff;
      rsp_status_in = rsp_status_ff;
      rsp_addr_in   = rsp_addr_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;

      rd_en   = 1'b0;
      rd_idx  = '0;
      wr_en   = 1'b0;
      wr_idx  = '0;
      wr_data = '0;

      round_sum   = {1'b0, req_size} + 17'd15;
      target_wide = 32'(req_addr[15:ffha_pkg::GRAN_SHIFT]) - 32'd1;
      cur_plus    = 32'(cur_ff) + 32'd1;
      walk_sum    = {1'b0, cur_ff} + {1'b0, rsize};
      after_sum   = {1'b0, target_ff} + {1'b0, rsize};
      prev_end    = {1'b0, prev_ff} + {1'b0, prev_size_ff};
      rest_wide   = 32'(cur_ff) + 32'(need_ff);

      unique case (state_ff)
         ffha_pkg::ST_INIT: begin
            // one free block covering the whole heap
            wr_en    = 1'b1;
            wr_idx   = '0;
            wr_data  = {NIL, NIL, 1'b0};
            state_in = ffha_pkg::ST_IDLE;
         end

         ffha_pkg::ST_IDLE: begin
            if (req_accept) begin
               if (req_tuser == ffha_pkg::CMD_ALLOC) begin
                  need_in = ffha_pkg::NEED_W'(round_sum >> ffha_pkg::GRAN_SHIFT)
                            + ffha_pkg::NEED_W'(1);
                  cur_in  = first_free_ff;
                  prev_in = NIL;
                  if (first_free_ff == NIL) begin
                     res_status_in = ffha_pkg::STATUS_NO_FIT;
                     res_addr_in   = '0;
                     state_in      = ffha_pkg::ST_RESP;
                  end else begin
                     rd_en    = 1'b1;
                     rd_idx   = first_free_ff;
                     state_in = ffha_pkg::ST_A_CHK;
                  end
               end else begin
                  res_addr_in = '0;
                  if (req_addr == 16'd0 || req_addr[ffha_pkg::GRAN_SHIFT-1:0] != '0 ||
                      target_wide >= 32'(NGRAN)) begin
                     res_status_in = ffha_pkg::STATUS_IGNORED;
                     state_in      = ffha_pkg::ST_RESP;
                  end else begin
                     // walk the heap from offset 0
                     target_in = GW'(target_wide);
                     cur_in    = '0;
                     prev_in   = NIL;
                     rd_en     = 1'b1;
                     rd_idx    = '0;
                     state_in  = ffha_pkg::ST_F_CHK;
                  end
               end
            end
         end

         ffha_pkg::ST_A_CHK: begin
            if (32'(rsize) >= 32'(need_ff)) begin
               hsize_in = rsize;
               hnext_in = rnext;
               link_in  = rnext;
               if (32'(rsize) != 32'(need_ff)) begin
                  state_in = ffha_pkg::ST_A_SPLIT;
               end else begin
                  state_in = ffha_pkg::ST_A_LINK;
               end
            end else begin
               prev_in      = cur_ff;
               prev_size_in = rsize;
               if (rnext == NIL) begin
                  res_status_in = ffha_pkg::STATUS_NO_FIT;
                  res_addr_in   = '0;
                  state_in      = ffha_pkg::ST_RESP;
               end else begin
                  // advance along the free list, one header a cycle
                  cur_in = rnext;
                  rd_en  = 1'b1;
                  rd_idx = rnext;
               end
            end
         end

         ffha_pkg::ST_A_SPLIT: begin
            // remainder takes the old block's place in the list
            wr_en    = 1'b1;
            wr_idx   = GW'(rest_wide);
            wr_data  = {GW'(32'(hsize_ff) - 32'(need_ff)), hnext_ff, 1'b0};
            link_in  = GW'(rest_wide);
            state_in = ffha_pkg::ST_A_LINK;
         end

         ffha_pkg::ST_A_LINK: begin
            if (prev_ff != NIL) begin
               wr_en   = 1'b1;
               wr_idx  = prev_ff;
               wr_data = {prev_size_ff, link_ff, 1'b0};
            end else begin
               first_free_in = link_ff;
            end
            state_in = ffha_pkg::ST_A_TAKE;
         end

         ffha_pkg::ST_A_TAKE: begin
            wr_en         = 1'b1;
            wr_idx        = cur_ff;
            wr_data       = {GW'(need_ff), NIL, 1'b1};
            res_status_in = ffha_pkg::STATUS_ALLOCATED;
            res_addr_in   = {cur_plus[11:0], 4'b0000};
            state_in      = ffha_pkg::ST_RESP;
         end

         ffha_pkg::ST_F_CHK: begin
            if (cur_ff == target_ff) begin
               if (!rused) begin
                  res_status_in = ffha_pkg::STATUS_IGNORED;
                  state_in      = ffha_pkg::ST_RESP;
               end else begin
                  hsize_in = rsize;
                  hnext_in = (prev_ff != NIL) ? prev_next_ff : first_free_ff;
                  if (after_sum < (GW+1)'(NGRAN)) begin
                     rd_en    = 1'b1;
                     rd_idx   = GW'(after_sum);
                     state_in = ffha_pkg::ST_F_AFTER;
                  end else begin
                     state_in = ffha_pkg::ST_F_WT;
                  end
               end
            end else begin
               if (!rused) begin
                  prev_in      = cur_ff;
                  prev_size_in = rsize;
                  prev_next_in = rnext;
               end
               // stop once the walk leaves the heap or steps over the target
               if (rsize == '0 || walk_sum >= (GW+1)'(NGRAN) ||
                   walk_sum > {1'b0, target_ff}) begin
                  res_status_in = ffha_pkg::STATUS_IGNORED;
                  state_in      = ffha_pkg::ST_RESP;
               end else begin
                  cur_in = GW'(walk_sum);
                  rd_en  = 1'b1;
                  rd_idx = GW'(walk_sum);
               end
            end
         end

         ffha_pkg::ST_F_AFTER: begin
            // merge with the free block right after
            if (!rused) begin
               hsize_in = GW'(32'(hsize_ff) + 32'(rsize));
               hnext_in = rnext;
            end
            state_in = ffha_pkg::ST_F_WT;
         end

         ffha_pkg::ST_F_WT: begin
            wr_en   = 1'b1;
            wr_idx  = target_ff;
            wr_data = {hsize_ff, hnext_ff, 1'b0};
            if (prev_ff == NIL) begin
               first_free_in = target_ff;
               res_status_in = ffha_pkg::STATUS_FREED;
               state_in      = ffha_pkg::ST_RESP;
            end else begin
               state_in = ffha_pkg::ST_F_WL;
            end
         end

         ffha_pkg::ST_F_WL: begin
            wr_en  = 1'b1;
            wr_idx = prev_ff;
            if (prev_end == {1'b0, target_ff}) begin
               // merge into the free block right before
               wr_data = {GW'(32'(prev_size_ff) + 32'(hsize_ff)), hnext_ff, 1'b0};
            end else begin
               wr_data = {prev_size_ff, target_ff, 1'b0};
            end
            res_status_in = ffha_pkg::STATUS_FREED;
            state_in      = ffha_pkg::ST_RESP;
         end

         ffha_pkg::ST_RESP: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_addr_in   = res_addr_ff;
               state_in      = ffha_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = ffha_pkg::ST_IDLE;
         end
      endcase
   end

   a_wr_in_heap: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (wr_idx < NIL))
      else $error("header write outside the heap");

   a_first_free_range: assert property (@(posedge clock) disable iff (reset)
      first_free_ff <= NIL)
      else $error("first free link out of range");

   a_one_in_work: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> !req_tready)
      else $error("request accepted while another is in work");

   a_addr_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != ffha_pkg::STATUS_ALLOCATED) |-> (rsp_addr_ff == 16'd0))
      else $error("nonzero data offset on a non-allocate result");

endmodule

`default_nettype wire

/* dv/first_fit_heap_allocator_tb.sv */
`timescale 1ns / 1ps

module first_fit_heap_allocator_tb;

   localparam int HEAP_BYTES = 65536;
   localparam int NGRAN = HEAP_BYTES / 16;
   // give up after this many cycles with no request or response moving
   localparam int STALL_LIMIT = 20000;
   // length of the one long response back-pressure episode
   localparam int HOLD_CYCLES = 200;
   localparam int RANDOM_REQUESTS = 120;

   // granule index; the value NGRAN stands for "no block"
   typedef logic [12:0] gran_type;
   localparam gran_type GRAN_END = gran_type'(NGRAN);

   typedef struct packed {
      logic        command;
      logic [15:0] request_size;
      logic [15:0] free_address;
   } heap_request_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] data_address;
   } heap_result_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;   // [15:0] request_size, [31:16] free_address
   logic        req_tuser = 1'b0; // [0] command
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;        // [15:0] data_address
   logic [1:0]  rsp_tuser;        // [1:0] status

   first_fit_heap_allocator #(
      .HEAP_BYTES(HEAP_BYTES)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

   // shadow heap: one header per granule, plus a spare slot at the null index
   gran_type blk_size [0:NGRAN];
   gran_type blk_next [0:NGRAN];
   logic     blk_used [0:NGRAN];
   gran_type first_free;

   heap_request_type pending_requests[$];
   heap_result_type  expected_results[$];
   logic [15:0]      live_offsets[$];     // data offsets currently allocated

   heap_request_type next_req;
   heap_result_type  want;
   heap_result_type  got;
   int               mismatches = 0;
   int               quiet_cycles = 0;
   int               hold_left = 0;
   logic             no_idle = 1'b0;
   logic             hold_go = 1'b0;
   logic             hold_done = 1'b0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
   end

   // Apply one request to the shadow heap and return the response it must give.
   function automatic heap_result_type predict_heap_op(input logic command,
                                                       input logic [15:0] request_size,
                                                       input logic [15:0] free_address);
      heap_result_type res;
      gran_type        need;
      gran_type        prev;
      gran_type        cur;
      gran_type        rest;
      gran_type        link;
      gran_type        target;
      gran_type        walk;
      gran_type        last_free;
      gran_type        after;
      int              guard;

      res.data_address = 16'd0;
      if (command == ffha_pkg::CMD_ALLOC) begin
         // round up to whole granules and add the header granule
         need = gran_type'(({1'b0, request_size} + 17'd15) >> 4) + 13'd1;
         prev = GRAN_END;
         cur = first_free;
         guard = 0;
         while (cur < GRAN_END && blk_size[cur] < need && guard < NGRAN) begin
            prev = cur;
            cur = blk_next[cur];
            guard++;
         end
         if (cur >= GRAN_END || blk_size[cur] < need) begin
            res.status = ffha_pkg::STATUS_NO_FIT;
            return res;
         end
         // split off the tail as a new free block, or unlink on an exact fit
         if (blk_size[cur] != need) begin
            rest = cur + need;
            blk_size[rest] = blk_size[cur] - need;
            blk_next[rest] = blk_next[cur];
            blk_used[rest] = 1'b0;
            link = rest;
         end else begin
            link = blk_next[cur];
         end
         if (prev != GRAN_END) begin
            blk_next[prev] = link;
         end else begin
            first_free = link;
         end
         blk_used[cur] = 1'b1;
         blk_size[cur] = need;
         blk_next[cur] = GRAN_END;
         res.status = ffha_pkg::STATUS_ALLOCATED;
         // header in the last granule wraps the offset to zero
         res.data_address = {cur[11:0] + 12'd1, 4'b0000};
         return res;
      end

      res.status = ffha_pkg::STATUS_IGNORED;
      if (free_address == 16'd0 || free_address[3:0] != 4'd0) begin
         return res;
      end
      target = {1'b0, free_address[15:4] - 12'd1};
      // walk the heap in address order, remembering the last free block passed
      walk = '0;
      last_free = GRAN_END;
      while (walk < GRAN_END && walk != target) begin
         if (!blk_used[walk]) begin
            last_free = walk;
         end
         if (blk_size[walk] == '0) begin
            return res;
         end
         walk = walk + blk_size[walk];
      end
      if (walk != target || !blk_used[target]) begin
         return res;
      end
      blk_used[target] = 1'b0;
      if (last_free != GRAN_END) begin
         blk_next[target] = blk_next[last_free];
         blk_next[last_free] = target;
      end else begin
         blk_next[target] = first_free;
         first_free = target;
      end
      // merge with the following block, never past the heap end
      after = target + blk_size[target];
      if (after < GRAN_END && !blk_used[after]) begin
         blk_size[target] = blk_size[target] + blk_size[after];
         blk_next[target] = blk_next[after];
      end
      // then fold into the preceding free block when it touches
      if (last_free != GRAN_END && last_free + blk_size[last_free] == target) begin
         blk_size[last_free] = blk_size[last_free] + blk_size[target];
         blk_next[last_free] = blk_next[target];
      end
      res.status = ffha_pkg::STATUS_FREED;
      return res;
   endfunction

   // Request driver: hold valid until accepted, then load the next queued
   // request or drop valid when the queue is empty or the random draw idles.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (pending_requests.size() != 0 && (no_idle || $urandom_range(99) >= 38)) begin
            next_req = pending_requests.pop_front();
            req_tvalid <= 1'b1;
            req_tdata <= {next_req.free_address, next_req.request_size};
            req_tuser <= next_req.command;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Response sink: random back-pressure, plus one long hold-off on demand.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         hold_left <= 0;
      end else if (hold_go && !hold_done) begin
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= no_idle || ($urandom_range(99) >= 38);
      end
   end

   // Monitor: check the response first, then predict the request accepted in
   // the same cycle so its expectation lands behind the older ones.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_results.size() == 0) begin
               $error("unexpected response: status %0d data_address 0x%04h",
                      rsp_tuser, rsp_tdata);
               mismatches++;
            end else begin
               want = expected_results.pop_front();
               if (rsp_tuser !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_tuser);
                  mismatches++;
               end
               if (rsp_tdata !== want.data_address) begin
                  $error("data_address: expected 0x%04h, got 0x%04h",
                         want.data_address, rsp_tdata);
                  mismatches++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            got = predict_heap_op(req_tuser, req_tdata[15:0], req_tdata[31:16]);
            expected_results.push_back(got);
            // track what may be freed later; offset zero can never be named
            if (got.status == ffha_pkg::STATUS_ALLOCATED && got.data_address != 16'd0) begin
               live_offsets.push_back(got.data_address);
            end else if (got.status == ffha_pkg::STATUS_FREED) begin
               foreach (live_offsets[i]) begin
                  if (live_offsets[i] == req_tdata[31:16]) begin
                     live_offsets.delete(i);
                     break;
                  end
               end
            end
         end
      end
   end

   // Watchdog: count cycles in which neither channel moves anything.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Queue one request, keeping the backlog short so the random mix can
   // follow the live allocations.
   task automatic offer(input logic command, input logic [15:0] request_size,
                        input logic [15:0] free_address);
      heap_request_type item;
      while (pending_requests.size() >= 4) @(negedge clock);
      item.command = command;
      item.request_size = request_size;
      item.free_address = free_address;
      pending_requests.push_back(item);
   endtask

   task automatic drain_all();
      while (pending_requests.size() != 0 || req_tvalid || expected_results.size() != 0) begin
         @(negedge clock);
      end
   endtask

   initial begin
      int          r;
      logic [15:0] sz;

      // reset image of the heap: one free block spanning every granule
      for (int g = 0; g <= NGRAN; g++) begin
         blk_size[g] = '0;
         blk_next[g] = '0;
         blk_used[g] = 1'b0;
      end
      blk_size[0] = GRAN_END;
      blk_next[0] = GRAN_END;
      first_free = '0;

      @(negedge clock);
      while (reset) @(negedge clock);

      // directed: header-only block, small splits, oversize request
      offer(ffha_pkg::CMD_ALLOC, 16'd0, 16'hFFFF);
      offer(ffha_pkg::CMD_ALLOC, 16'd1, 16'($urandom));
      offer(ffha_pkg::CMD_ALLOC, 16'd16, 16'($urandom));
      offer(ffha_pkg::CMD_ALLOC, 16'hFFFF, 16'($urandom));
      // null, misaligned and unknown-block frees
      offer(ffha_pkg::CMD_FREE, 16'hFFFF, 16'd0);
      offer(ffha_pkg::CMD_FREE, 16'($urandom), 16'd33);
      offer(ffha_pkg::CMD_FREE, 16'($urandom), 16'd48);
      // free, double free, merge after, then merge on both sides
      offer(ffha_pkg::CMD_FREE, 16'($urandom), 16'd32);
      offer(ffha_pkg::CMD_FREE, 16'($urandom), 16'd32);
      offer(ffha_pkg::CMD_FREE, 16'($urandom), 16'd16);
      offer(ffha_pkg::CMD_FREE, 16'($urandom), 16'd64);
      // exact fit of the whole heap, no fit on an empty free list
      offer(ffha_pkg::CMD_ALLOC, 16'd65520, 16'($urandom));
      offer(ffha_pkg::CMD_ALLOC, 16'd0, 16'($urandom));
      // free against the heap end, then a misaligned offset
      offer(ffha_pkg::CMD_FREE, 16'($urandom), 16'd16);
      offer(ffha_pkg::CMD_FREE, 16'($urandom), 16'hFFFF);
      // header-only block in the last granule reports offset zero
      offer(ffha_pkg::CMD_ALLOC, 16'd65504, 16'($urandom));
      offer(ffha_pkg::CMD_ALLOC, 16'd0, 16'($urandom));
      offer(ffha_pkg::CMD_FREE, 16'($urandom), 16'd65520);
      offer(ffha_pkg::CMD_FREE, 16'($urandom), 16'd0);
      offer(ffha_pkg::CMD_FREE, 16'($urandom), 16'd16);

      for (int n = 0; n < RANDOM_REQUESTS; n++) begin
         if (n == 40) begin
            // stall the response side long enough to back the block up
            hold_go = 1'b1;
         end
         if (n == 80) begin
            // sender pause: let every outstanding response come back
            drain_all();
         end
         if (n == 90) begin
            no_idle = 1'b1;
         end
         if (n == 110) begin
            no_idle = 1'b0;
         end

         r = $urandom_range(99);
         if (r < 50 || (r < 85 && live_offsets.size() == 0)) begin
            // mostly small sizes, some large enough to run the heap dry
            if ($urandom_range(9) == 0) begin
               sz = 16'($urandom);
            end else if ($urandom_range(4) == 0) begin
               sz = 16'($urandom_range(16383, 2048));
            end else begin
               sz = 16'($urandom_range(300));
            end
            offer(ffha_pkg::CMD_ALLOC, sz, 16'($urandom));
         end else if (r < 85) begin
            offer(ffha_pkg::CMD_FREE, 16'($urandom),
                  live_offsets[$urandom_range(live_offsets.size() - 1)]);
         end else begin
            // noise: null, arbitrary, or aligned but probably not a block
            case ($urandom_range(2))
               0: begin
                  offer(ffha_pkg::CMD_FREE, 16'($urandom), 16'd0);
               end
               1: begin
                  offer(ffha_pkg::CMD_FREE, 16'($urandom), 16'($urandom));
               end
               default: begin
                  offer(ffha_pkg::CMD_FREE, 16'($urandom),
                        {12'($urandom_range(4095)), 4'b0000});
               end
            endcase
         end
      end

      drain_all();
      // watch a while longer for stray responses
      repeat (64) @(negedge clock);
      if (mismatches == 0 && expected_results.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
